[sv/csgc_pkg.sv]
`timescale 1ns / 1ps
// shared widths, register indexes, channel and phase codes, control structs
// for the gated counter color classifier; no dependencies

package csgc_pkg;

    // field widths
    localparam int GATE_W     = 24;
    localparam int CNT_W      = 15;
    localparam int LVL_W      = 8;
    localparam int CLS_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // default saturation point of the edge counter
    localparam int COUNT_MAX_DEF = 30000;

    // divider sequencing: one quotient bit per step plus one clamp check
    localparam int STEP_W = $clog2(LVL_W + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GATE_TICKS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_RED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_GREEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_BLUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_RED   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_GREEN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_BLUE  = 3'd6;

    // normalization channel order
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // gate phases, in the order the gates run
    localparam logic [1:0] PH_RED   = 2'd0;
    localparam logic [1:0] PH_BLUE  = 2'd1;
    localparam logic [1:0] PH_GREEN = 2'd2;

    // color class codes
    localparam logic [CLS_W-1:0] CLS_BLACK   = 3'd0;
    localparam logic [CLS_W-1:0] CLS_WHITE   = 3'd1;
    localparam logic [CLS_W-1:0] CLS_YELLOW  = 3'd2;
    localparam logic [CLS_W-1:0] CLS_RED     = 3'd3;
    localparam logic [CLS_W-1:0] CLS_GREEN   = 3'd4;
    localparam logic [CLS_W-1:0] CLS_BLUE    = 3'd5;
    localparam logic [CLS_W-1:0] CLS_UNKNOWN = 3'd6;

    // commands from controller to datapath
    typedef struct packed {
        logic              accept;
        logic              div_setup;
        logic              div_step;
        logic              div_store;
        logic              class_load;
        logic [1:0]        chan;
        logic [STEP_W-1:0] step_idx;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic frame_close;
    } sts_t;

endpackage

[sv/csgc_ctrl.sv]
`timescale 1ns / 1ps
// controller for the gated counter color classifier: handshakes and the
// normalization sequence; depends on csgc_pkg

module csgc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  csgc_pkg::sts_t   sts,
    output csgc_pkg::cmd_t   cmd
);
    import csgc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_STEP,
        S_STORE,
        S_CLASS
    } state_t;

    localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(LVL_W);

    state_t            state_reg, state_next;
    logic [1:0]        chan_reg, chan_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        chan_next      = chan_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.chan       = chan_reg;
        cmd.step_idx   = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = !out_valid_reg || out_ready;
                cmd.accept = in_valid && in_ready;
                if (cmd.accept)
                begin
                    if (sts.frame_close)
                    begin
                        chan_next  = CH_RED;
                        state_next = S_SETUP;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_SETUP:
            begin
                cmd.div_setup = 1'b1;
                step_next     = STEP_TOP;
                state_next    = S_STEP;
            end
            S_STEP:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_STORE:
            begin
                cmd.div_store = 1'b1;
                if (chan_reg == CH_BLUE)
                begin
                    state_next = S_CLASS;
                end
                else
                begin
                    chan_next  = chan_reg + 2'd1;
                    state_next = S_SETUP;
                end
            end
            S_CLASS:
            begin
                cmd.class_load = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chan_reg      <= CH_RED;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[sv/csgc_dp.sv]
`timescale 1ns / 1ps
// datapath for the gated counter color classifier: config registers, gate
// and edge counters, restoring divider, classifier, result register; uses csgc_pkg

module csgc_dp #(
    parameter int COUNT_MAX = csgc_pkg::COUNT_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  csgc_pkg::cmd_t                      cmd,
    output csgc_pkg::sts_t                      sts,
    input  logic                                sensor_level,
    input  logic                                cfg_valid,
    input  logic [csgc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csgc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                frame_done,
    output logic                                select_s2,
    output logic                                select_s3,
    output logic [csgc_pkg::CNT_W-1:0]          raw_red,
    output logic [csgc_pkg::CNT_W-1:0]          raw_green,
    output logic [csgc_pkg::CNT_W-1:0]          raw_blue,
    output logic [csgc_pkg::LVL_W-1:0]          level_red,
    output logic [csgc_pkg::LVL_W-1:0]          level_green,
    output logic [csgc_pkg::LVL_W-1:0]          level_blue,
    output logic [csgc_pkg::CLS_W-1:0]          color_class
);
    import csgc_pkg::*;

    localparam int EDGE_W = $clog2(COUNT_MAX + 1);
    localparam logic [EDGE_W-1:0] EDGE_LIMIT = EDGE_W'(COUNT_MAX);
    localparam int NUM_W  = CNT_W + LVL_W;
    localparam int QIDX_W = $clog2(LVL_W);
    localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(LVL_W);
    localparam logic [LVL_W-1:0] DARK_LIMIT   = LVL_W'(30);
    localparam logic [LVL_W-1:0] BRIGHT_LIMIT = LVL_W'(200);

    // color decision on normalized levels, ratio tests as cross products
    function automatic logic [CLS_W-1:0] classify(
        input logic [LVL_W-1:0] r,
        input logic [LVL_W-1:0] g,
        input logic [LVL_W-1:0] b
    );
        logic [LVL_W+1:0] sum;
        logic [LVL_W+2:0] r5;
        logic [LVL_W+2:0] g5;
        logic [LVL_W+2:0] sum2;
        sum  = {2'b00, r} + {2'b00, g} + {2'b00, b};
        r5   = ({3'b000, r} << 2) + {3'b000, r};
        g5   = ({3'b000, g} << 2) + {3'b000, g};
        sum2 = {sum, 1'b0};
        if (sum == '0)
            return CLS_BLACK;
        else if (r < DARK_LIMIT && g < DARK_LIMIT && b < DARK_LIMIT)
            return CLS_BLACK;
        else if (r > BRIGHT_LIMIT && g > BRIGHT_LIMIT && b > BRIGHT_LIMIT)
            return CLS_WHITE;
        else if (r5 > sum2 && g5 > sum2)
            return CLS_YELLOW;
        else if (r > g && r > b)
            return CLS_RED;
        else if (g > r && g > b)
            return CLS_GREEN;
        else if (b > r && b > g)
            return CLS_BLUE;
        else
            return CLS_UNKNOWN;
    endfunction

    // configuration registers
    logic [GATE_W-1:0] gate_ticks_reg;
    logic [CNT_W-1:0]  black_red_reg, black_green_reg, black_blue_reg;
    logic [CNT_W-1:0]  white_red_reg, white_green_reg, white_blue_reg;

    // counting state
    logic [1:0]        phase_reg, phase_next;
    logic [GATE_W-1:0] gate_reg;
    logic [EDGE_W-1:0] edge_reg;
    logic              prev_reg;
    logic [CNT_W-1:0]  held_red_reg, held_blue_reg, held_red_next, held_blue_next;

    // divider state
    logic [NUM_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [LVL_W-1:0]  quo_reg;
    logic              clamp_reg;
    logic              zero_reg;

    // result register
    logic              frame_done_reg, select_s2_reg, select_s3_reg;
    logic [CNT_W-1:0]  raw_red_reg, raw_green_reg, raw_blue_reg;
    logic [LVL_W-1:0]  level_red_reg, level_green_reg, level_blue_reg;
    logic [CLS_W-1:0]  class_reg;

    logic [GATE_W-1:0] ticks;
    logic [GATE_W-1:0] gate_inc;
    logic              gate_close;
    logic [EDGE_W-1:0] edge_new;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  sel_val, sel_lo, sel_hi;
    logic [CNT_W-1:0]  diff;
    logic [NUM_W-1:0]  den_sh;
    logic              rem_ge;
    logic [LVL_W-1:0]  level_out;

    assign frame_done  = frame_done_reg;
    assign select_s2   = select_s2_reg;
    assign select_s3   = select_s3_reg;
    assign raw_red     = raw_red_reg;
    assign raw_green   = raw_green_reg;
    assign raw_blue    = raw_blue_reg;
    assign level_red   = level_red_reg;
    assign level_green = level_green_reg;
    assign level_blue  = level_blue_reg;
    assign color_class = class_reg;

    // gate window and saturating edge count
    assign ticks      = (gate_ticks_reg == '0) ? GATE_W'(1) : gate_ticks_reg;
    assign gate_inc   = gate_reg + 1'b1;
    assign gate_close = gate_inc >= ticks;
    assign edge_new   = (sensor_level && !prev_reg && edge_reg < EDGE_LIMIT)
                        ? edge_reg + 1'b1 : edge_reg;
    assign cnt        = CNT_W'(edge_new);

    assign sts.frame_close = gate_close && (phase_reg == PH_GREEN);

    // phase advance at a gate close, spare phase code runs as red
    always_comb
    begin
        phase_next     = phase_reg;
        held_red_next  = held_red_reg;
        held_blue_next = held_blue_reg;
        if (gate_close)
        begin
            case (phase_reg)
                PH_BLUE:
                begin
                    held_blue_next = cnt;
                    phase_next     = PH_GREEN;
                end
                PH_GREEN:
                begin
                    phase_next = PH_RED;
                end
                default:
                begin
                    held_red_next = cnt;
                    phase_next    = PH_BLUE;
                end
            endcase
        end
    end

    // channel select for normalization
    always_comb
    begin
        case (cmd.chan)
            CH_GREEN:
            begin
                sel_val = raw_green_reg;
                sel_lo  = black_green_reg;
                sel_hi  = white_green_reg;
            end
            CH_BLUE:
            begin
                sel_val = raw_blue_reg;
                sel_lo  = black_blue_reg;
                sel_hi  = white_blue_reg;
            end
            default:
            begin
                sel_val = raw_red_reg;
                sel_lo  = black_red_reg;
                sel_hi  = white_red_reg;
            end
        endcase
    end

    // divider step compare and final level
    assign diff      = sel_val - sel_lo;
    assign den_sh    = {{LVL_W{1'b0}}, den_reg} << cmd.step_idx;
    assign rem_ge    = rem_reg >= den_sh;
    assign level_out = zero_reg ? '0 : (clamp_reg ? '1 : quo_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_ticks_reg  <= GATE_W'(1000000);
            black_red_reg   <= '0;
            black_green_reg <= '0;
            black_blue_reg  <= '0;
            white_red_reg   <= CNT_W'(1);
            white_green_reg <= CNT_W'(1);
            white_blue_reg  <= CNT_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GATE_TICKS:  gate_ticks_reg  <= cfg_data[GATE_W-1:0];
                REG_BLACK_RED:   black_red_reg   <= cfg_data[CNT_W-1:0];
                REG_BLACK_GREEN: black_green_reg <= cfg_data[CNT_W-1:0];
                REG_BLACK_BLUE:  black_blue_reg  <= cfg_data[CNT_W-1:0];
                REG_WHITE_RED:   white_red_reg   <= cfg_data[CNT_W-1:0];
                REG_WHITE_GREEN: white_green_reg <= cfg_data[CNT_W-1:0];
                REG_WHITE_BLUE:  white_blue_reg  <= cfg_data[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // counting state, advanced once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_RED;
            gate_reg      <= '0;
            edge_reg      <= '0;
            prev_reg      <= 1'b0;
            held_red_reg  <= '0;
            held_blue_reg <= '0;
        end
        else if (cmd.accept)
        begin
            prev_reg      <= sensor_level;
            phase_reg     <= phase_next;
            held_red_reg  <= held_red_next;
            held_blue_reg <= held_blue_next;
            if (gate_close)
            begin
                gate_reg <= '0;
                edge_reg <= '0;
            end
            else
            begin
                gate_reg <= gate_inc;
                edge_reg <= edge_new;
            end
        end
    end

    // restoring divider, one quotient bit per step, top step checks the clamp
    always_ff @(posedge clk)
    begin
        if (cmd.div_setup)
        begin
            zero_reg  <= (sel_hi <= sel_lo) || (sel_val <= sel_lo);
            rem_reg   <= {diff, {LVL_W{1'b0}}} - NUM_W'(diff);
            den_reg   <= sel_hi - sel_lo;
            quo_reg   <= '0;
            clamp_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            if (cmd.step_idx == STEP_TOP)
            begin
                clamp_reg <= rem_ge;
            end
            else if (rem_ge)
            begin
                rem_reg                              <= rem_reg - den_sh;
                quo_reg[cmd.step_idx[QIDX_W-1:0]] <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            select_s2_reg   <= (phase_next == PH_GREEN);
            select_s3_reg   <= (phase_next == PH_BLUE) || (phase_next == PH_GREEN);
            level_red_reg   <= '0;
            level_green_reg <= '0;
            level_blue_reg  <= '0;
            class_reg       <= CLS_BLACK;
            if (sts.frame_close)
            begin
                frame_done_reg <= 1'b1;
                raw_red_reg    <= held_red_reg;
                raw_green_reg  <= cnt;
                raw_blue_reg   <= held_blue_reg;
            end
            else
            begin
                frame_done_reg <= 1'b0;
                raw_red_reg    <= '0;
                raw_green_reg  <= '0;
                raw_blue_reg   <= '0;
            end
        end
        else if (cmd.div_store)
        begin
            case (cmd.chan)
                CH_GREEN: level_green_reg <= level_out;
                CH_BLUE:  level_blue_reg  <= level_out;
                default:  level_red_reg   <= level_out;
            endcase
        end
        else if (cmd.class_load)
        begin
            class_reg <= classify(level_red_reg, level_green_reg, level_blue_reg);
        end
    end

endmodule

[sv/color_sensor_gated_counter_classifier_top.sv]
`timescale 1ns / 1ps
// Gated edge counter and color classifier for a light-to-frequency sensor. One sensor
// sample is taken per item and one result item is returned per sample; the block
// accepts a new sample every cycle while results are taken and no frame is being
// normalized. For the sample that closes the green gate, the three counts are
// normalized one after another on a shared restoring divider that produces one quotient
// bit per step (setup, nine steps with the top one a clamp check, and a store per
// color), then a classify state loads the class. Config writes are always accepted and
// must be made while no sample is in flight.

module color_sensor_gated_counter_classifier_top #(
    parameter int COUNT_MAX = csgc_pkg::COUNT_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                sensor_level,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                frame_done,
    output logic                                select_s2,
    output logic                                select_s3,
    output logic [csgc_pkg::CNT_W-1:0]          raw_red,
    output logic [csgc_pkg::CNT_W-1:0]          raw_green,
    output logic [csgc_pkg::CNT_W-1:0]          raw_blue,
    output logic [csgc_pkg::LVL_W-1:0]          level_red,
    output logic [csgc_pkg::LVL_W-1:0]          level_green,
    output logic [csgc_pkg::LVL_W-1:0]          level_blue,
    output logic [csgc_pkg::CLS_W-1:0]          color_class,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [csgc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csgc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import csgc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // sequencing and handshakes
    csgc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // counters, divider, classifier and result register
    csgc_dp #(
        .COUNT_MAX (COUNT_MAX)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .sensor_level (sensor_level),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .frame_done   (frame_done),
        .select_s2    (select_s2),
        .select_s3    (select_s3),
        .raw_red      (raw_red),
        .raw_green    (raw_green),
        .raw_blue     (raw_blue),
        .level_red    (level_red),
        .level_green  (level_green),
        .level_blue   (level_blue),
        .color_class  (color_class)
    );

endmodule

[sv/csgc_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the gated counter color classifier and the bind that
// attaches them to the top level; depends on csgc_pkg

module csgc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                frame_done,
    input  logic                                select_s2,
    input  logic                                select_s3,
    input  logic [csgc_pkg::CNT_W-1:0]          raw_red,
    input  logic [csgc_pkg::CNT_W-1:0]          raw_green,
    input  logic [csgc_pkg::CNT_W-1:0]          raw_blue,
    input  logic [csgc_pkg::LVL_W-1:0]          level_red,
    input  logic [csgc_pkg::LVL_W-1:0]          level_green,
    input  logic [csgc_pkg::LVL_W-1:0]          level_blue,
    input  logic [csgc_pkg::CLS_W-1:0]          color_class
);
    import csgc_pkg::*;

    // a full result register that is not taken blocks new items
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("item accepted while result stalled");

    // a pending result holds until taken
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_done)
            && $stable(color_class) && $stable(raw_green))
        else $error("pending result changed");

    // a finished frame hands the filters back to red
    a_frame_back_to_red: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> !select_s2 && !select_s3)
        else $error("frame result does not select red");

    // green gate drives both select lines, s2 alone never shows
    a_select_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && select_s2 |-> select_s3)
        else $error("invalid filter select pair");

    // results outside a frame carry zero counts and levels and the black class
    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_done |-> raw_red == '0 && raw_green == '0
            && raw_blue == '0 && level_red == '0 && level_green == '0
            && level_blue == '0 && color_class == CLS_BLACK)
        else $error("non-frame result carries data");

endmodule

bind color_sensor_gated_counter_classifier_top csgc_checker u_csgc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_done  (frame_done),
    .select_s2   (select_s2),
    .select_s3   (select_s3),
    .raw_red     (raw_red),
    .raw_green   (raw_green),
    .raw_blue    (raw_blue),
    .level_red   (level_red),
    .level_green (level_green),
    .level_blue  (level_blue),
    .color_class (color_class)
);
